// File: src/least_loaded_server_registry_unit_macros.svh
// ----------------------------------------------------------------------------
// Least loaded server registry assertion macros
// Shared concurrent assertion forms for the registry RTL.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_SERVER_REGISTRY_UNIT_MACROS_SVH
`define LEAST_LOADED_SERVER_REGISTRY_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLSR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("registry assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LLSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("registry assertion failed");

`endif

// File: src/llsr_pkg.sv
// ----------------------------------------------------------------------------
// Registry package
// Operation and status codes and the table entry layouts.
// ----------------------------------------------------------------------------
package llsr_pkg;

   localparam int MODE_W    = 3;
   localparam int STATUS_W  = 3;
   localparam int EXPIRED_W = 7;
   localparam int REMOVED_W = 5;
   localparam int NUM_W     = 17;
   localparam int PROD_W    = 33;

   localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HEARTBEAT  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UNREGISTER = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LINK_DOWN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DRAIN      = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ASSIGN     = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SWEEP      = 3'd6;
   localparam logic [MODE_W-1:0] MODE_REVOKE     = 3'd7;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_SERVER = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RES_FULL  = 3'd4;

   localparam logic [1:0] CSR_TABLE_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_HB_PERIOD    = 2'd1;
   localparam logic [1:0] CSR_MISSED_BEATS = 2'd2;
   localparam logic [1:0] CSR_ORPHAN_GRACE = 2'd3;

   typedef struct packed {
      logic [15:0] id;
      logic [63:0] session;
      logic [31:0] host;
      logic [15:0] port;
      logic [15:0] capacity;
      logic [15:0] load;
      logic [47:0] last_beat;
      logic [47:0] orphan_time;
      logic        draining;
      logic        link_held;
   } srv_rec_type;

   typedef struct packed {
      logic [63:0] player;
      logic [15:0] server;
      logic [47:0] expiry;
      logic [31:0] ticket;
   } res_rec_type;

endpackage

// File: src/least_loaded_server_registry_unit.sv
// ----------------------------------------------------------------------------
// Least loaded server registry
// Register, heartbeat, unregister, link down, drain, assign, sweep and revoke.
// Each word walks table entries through the registered RAM read ports: table ops
// scan the servers, revoke the reservations, sweep the reservations then the
// servers, assign the servers, the reservations and then the servers again.
// One word at a time; the result strobe lasts one cycle and cannot be stalled.
// Synchronous reset empties both tables at once through their valid bits.
// ----------------------------------------------------------------------------
`include "least_loaded_server_registry_unit_macros.svh"

module least_loaded_server_registry_unit #(
   parameter int MAX_SERVERS      = 16,
   parameter int MAX_RESERVATIONS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [llsr_pkg::MODE_W-1:0]     req_mode,
   input  logic [63:0]                     req_session_key,
   input  logic [31:0]                     req_host_key,
   input  logic [15:0]                     req_host_port,
   input  logic [15:0]                     req_seat_capacity,
   input  logic [15:0]                     req_seat_current,
   input  logic [47:0]                     req_now_time,
   input  logic [63:0]                     req_player_key,
   input  logic [31:0]                     req_hold_time,
   input  logic [15:0]                     req_target_server,
   input  logic                            req_drain_flag,
   input  logic [31:0]                     req_ticket_in,
   output logic                            rsp_strobe,
   output logic [llsr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [15:0]                     rsp_chosen_server,
   output logic                            rsp_need_link,
   output logic                            rsp_stale_link,
   output logic [31:0]                     rsp_ticket_out,
   output logic [31:0]                     rsp_chosen_host,
   output logic [15:0]                     rsp_chosen_port,
   output logic [llsr_pkg::EXPIRED_W-1:0]  rsp_expired_count,
   output logic [llsr_pkg::REMOVED_W-1:0]  rsp_removed_count,
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_index,
   input  logic [31:0]                     csr_data
);

   import llsr_pkg::*;

   localparam int SW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int RW  = (MAX_RESERVATIONS > 1) ? $clog2(MAX_RESERVATIONS) : 1;
   localparam int SCW = $clog2(MAX_SERVERS + 1);
   localparam int RCW = $clog2(MAX_RESERVATIONS + 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SRD  = 4'd1;
   localparam logic [3:0] ST_SEV  = 4'd2;
   localparam logic [3:0] ST_MUL  = 4'd3;
   localparam logic [3:0] ST_CMP  = 4'd4;
   localparam logic [3:0] ST_RRD  = 4'd5;
   localparam logic [3:0] ST_REV  = 4'd6;
   localparam logic [3:0] ST_FIN  = 4'd7;

   logic [3:0]  state_ff;
   logic        phase_ff;
   logic [SW-1:0] sidx_ff;
   logic [RW-1:0] ridx_ff;

   logic [4:0]  table_limit_ff;
   logic [15:0] hb_period_ff;
   logic [7:0]  missed_beats_ff;
   logic [31:0] orphan_grace_ff;
   logic [23:0] timeout_ff;

   logic [MODE_W-1:0] mode_ff;
   logic [63:0] session_ff;
   logic [31:0] host_ff;
   logic [15:0] port_ff;
   logic [15:0] capacity_ff;
   logic [15:0] current_ff;
   logic [47:0] now_ff;
   logic [63:0] player_ff;
   logic [31:0] hold_ff;
   logic [15:0] target_ff;
   logic        drain_ff;
   logic [31:0] ticket_in_ff;

   logic        srv_valid_ff  [MAX_SERVERS];
   logic        srv_orphan_ff [MAX_SERVERS];
   logic [15:0] srv_id_ff     [MAX_SERVERS];
   logic [RCW-1:0] cnt_ff     [MAX_SERVERS];
   logic        res_valid_ff  [MAX_RESERVATIONS];
   logic [15:0] next_server_ff;
   logic [31:0] next_ticket_ff;

   logic        hit_found_ff;
   logic [SW-1:0] hit_idx_ff;
   srv_rec_type hit_rec_ff;
   logic        rev_found_ff;
   logic [SW-1:0] rev_idx_ff;
   srv_rec_type rev_rec_ff;
   logic [SCW-1:0] used_ff;
   logic        free_found_ff;
   logic [SW-1:0] free_idx_ff;

   logic        best_found_ff;
   srv_rec_type best_rec_ff;
   logic [NUM_W-1:0] best_num_ff;
   srv_rec_type cur_rec_ff;
   logic [NUM_W-1:0] cur_num_ff;
   logic        cur_ok_ff;
   logic [PROD_W-1:0] lhs_ff;
   logic [PROD_W-1:0] rhs_ff;

   logic        pl_found_ff;
   logic [RW-1:0] pl_idx_ff;
   logic [31:0] pl_ticket_ff;
   logic        rfree_found_ff;
   logic [RW-1:0] rfree_idx_ff;

   logic [EXPIRED_W-1:0] expired_ff;
   logic [REMOVED_W-1:0] removed_ff;
   logic        stale_ff;

   logic                 rsp_strobe_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [15:0]          rsp_chosen_ff;
   logic                 rsp_need_ff;
   logic                 rsp_stale_ff;
   logic [31:0]          rsp_ticket_ff;
   logic [31:0]          rsp_host_ff;
   logic [15:0]          rsp_port_ff;
   logic [EXPIRED_W-1:0] rsp_expired_ff;
   logic [REMOVED_W-1:0] rsp_removed_ff;

   logic [$bits(srv_rec_type)-1:0] srd_raw;
   logic [$bits(res_rec_type)-1:0] rrd_raw;
   srv_rec_type srd_rec;
   res_rec_type rrd_rec;

   logic        swr_en;
   logic [SW-1:0] swr_addr;
   srv_rec_type swr_data;
   logic        rwr_en;
   logic [RW-1:0] rwr_addr;
   res_rec_type rwr_data;

   logic        s_valid;
   logic        s_orphan;
   logic        mark_hit;
   logic        reap_hit;
   logic        rev_take;
   logic        reg_full;
   logic [31:0] limit_eff;
   logic        res_live;
   logic [48:0] expiry_sum;
   logic [47:0] expiry_sat;
   logic        cmp_take;
   logic        s_last;
   logic        r_last;
   logic [NUM_W-1:0] sel_num;
   logic        sel_ok;
   srv_rec_type fill_rec;

   assign srd_rec = srv_rec_type'(srd_raw);
   assign rrd_rec = res_rec_type'(rrd_raw);

   llsr_ram #(.WIDTH($bits(srv_rec_type)), .DEPTH(MAX_SERVERS)) u_srv_ram (
      .clock   (clock),
      .wr_en   (swr_en),
      .wr_addr (swr_addr),
      .wr_data (swr_data),
      .rd_addr (sidx_ff),
      .rd_data (srd_raw)
   );

   llsr_ram #(.WIDTH($bits(res_rec_type)), .DEPTH(MAX_RESERVATIONS)) u_res_ram (
      .clock   (clock),
      .wr_en   (rwr_en),
      .wr_addr (rwr_addr),
      .wr_data (rwr_data),
      .rd_addr (ridx_ff),
      .rd_data (rrd_raw)
   );

   always_comb begin
      s_valid  = srv_valid_ff[sidx_ff];
      s_orphan = srv_orphan_ff[sidx_ff];
      s_last   = (sidx_ff == SW'(MAX_SERVERS - 1));
      r_last   = (ridx_ff == RW'(MAX_RESERVATIONS - 1));
      mark_hit = s_valid && !s_orphan &&
                 ({1'b0, srd_rec.last_beat} + 49'(timeout_ff)) < {1'b0, now_ff};
      reap_hit = s_valid && s_orphan &&
                 ({1'b0, srd_rec.orphan_time} + 49'(orphan_grace_ff)) < {1'b0, now_ff};
      rev_take = s_valid && s_orphan && srd_rec.host == host_ff &&
                 srd_rec.port == port_ff &&
                 (!rev_found_ff || srd_rec.orphan_time > rev_rec_ff.orphan_time ||
                  (srd_rec.orphan_time == rev_rec_ff.orphan_time &&
                   srd_rec.id < rev_rec_ff.id));
      limit_eff = (32'(table_limit_ff) > 32'(MAX_SERVERS)) ? 32'(MAX_SERVERS)
                                                           : 32'(table_limit_ff);
      reg_full = (32'(used_ff) >= limit_eff) || !free_found_ff;
      res_live = res_valid_ff[ridx_ff] && rrd_rec.expiry > now_ff;
      expiry_sum = {1'b0, now_ff} + 49'(hold_ff);
      expiry_sat = expiry_sum[48] ? 48'hFFFF_FFFF_FFFF : expiry_sum[47:0];
      sel_num = NUM_W'(srd_rec.load) + NUM_W'(cnt_ff[sidx_ff]);
      sel_ok  = s_valid && !s_orphan && srd_rec.capacity != 16'd0 && !srd_rec.draining;
      cmp_take = cur_ok_ff && (!best_found_ff || lhs_ff < rhs_ff ||
                 (lhs_ff == rhs_ff && cur_rec_ff.id < best_rec_ff.id));

      if (hit_found_ff) begin
         fill_rec = hit_rec_ff;
      end else if (rev_found_ff) begin
         fill_rec = rev_rec_ff;
         fill_rec.link_held = 1'b1;
      end else begin
         fill_rec = hit_rec_ff;
         fill_rec.id = next_server_ff;
         fill_rec.draining = 1'b0;
         fill_rec.link_held = 1'b1;
      end
      fill_rec.session     = session_ff;
      fill_rec.host        = host_ff;
      fill_rec.port        = port_ff;
      fill_rec.capacity    = capacity_ff;
      fill_rec.load        = current_ff;
      fill_rec.last_beat   = now_ff;
      fill_rec.orphan_time = 48'd0;

      swr_en   = 1'b0;
      swr_addr = sidx_ff;
      swr_data = srd_rec;
      if (state_ff == ST_SEV && mode_ff == MODE_ASSIGN && !phase_ff && mark_hit) begin
         swr_en = 1'b1;
         swr_data.orphan_time = now_ff;
      end
      if (state_ff == ST_FIN) begin
         swr_addr = hit_idx_ff;
         swr_data = hit_rec_ff;
         case (mode_ff)
            MODE_REGISTER: begin
               swr_data = fill_rec;
               if (hit_found_ff) begin
                  swr_en = 1'b1;
               end else if (rev_found_ff) begin
                  swr_en = 1'b1;
                  swr_addr = rev_idx_ff;
               end else begin
                  swr_en = !reg_full;
                  swr_addr = free_idx_ff;
               end
            end
            MODE_HEARTBEAT: begin
               swr_en = hit_found_ff;
               swr_data.load = current_ff;
               swr_data.last_beat = now_ff;
               swr_data.orphan_time = 48'd0;
            end
            MODE_LINK_DOWN: begin
               swr_en = hit_found_ff;
               swr_data.link_held = 1'b0;
               if (!srv_orphan_ff[hit_idx_ff]) begin
                  swr_data.orphan_time = now_ff;
               end
            end
            MODE_DRAIN: begin
               swr_en = hit_found_ff;
               swr_data.draining = drain_ff;
            end
            default: begin
               swr_en = 1'b0;
            end
         endcase
      end

      rwr_en = (state_ff == ST_FIN) && mode_ff == MODE_ASSIGN && best_found_ff &&
               (pl_found_ff || rfree_found_ff);
      rwr_addr = pl_found_ff ? pl_idx_ff : rfree_idx_ff;
      rwr_data.player = player_ff;
      rwr_data.server = best_rec_ff.id;
      rwr_data.expiry = expiry_sat;
      rwr_data.ticket = next_ticket_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_strobe_ff   <= 1'b0;
         table_limit_ff  <= 5'd16;
         hb_period_ff    <= 16'd1000;
         missed_beats_ff <= 8'd3;
         orphan_grace_ff <= 32'd10000;
         next_server_ff  <= 16'd1;
         next_ticket_ff  <= 32'd1;
         for (int s = 0; s < MAX_SERVERS; s++) begin
            srv_valid_ff[s]  <= 1'b0;
            srv_orphan_ff[s] <= 1'b0;
         end
         for (int r = 0; r < MAX_RESERVATIONS; r++) begin
            res_valid_ff[r] <= 1'b0;
         end
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TABLE_LIMIT:  table_limit_ff  <= csr_data[4:0];
               CSR_HB_PERIOD:    hb_period_ff    <= csr_data[15:0];
               CSR_MISSED_BEATS: missed_beats_ff <= csr_data[7:0];
               CSR_ORPHAN_GRACE: orphan_grace_ff <= csr_data;
               default:          table_limit_ff  <= table_limit_ff;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  mode_ff      <= req_mode;
                  session_ff   <= req_session_key;
                  host_ff      <= req_host_key;
                  port_ff      <= req_host_port;
                  capacity_ff  <= req_seat_capacity;
                  current_ff   <= req_seat_current;
                  now_ff       <= req_now_time;
                  player_ff    <= req_player_key;
                  hold_ff      <= req_hold_time;
                  target_ff    <= req_target_server;
                  drain_ff     <= req_drain_flag;
                  ticket_in_ff <= req_ticket_in;
                  timeout_ff   <= 24'(hb_period_ff * missed_beats_ff);
                  sidx_ff      <= '0;
                  ridx_ff      <= '0;
                  phase_ff     <= 1'b0;
                  hit_found_ff <= 1'b0;
                  rev_found_ff <= 1'b0;
                  free_found_ff <= 1'b0;
                  used_ff      <= '0;
                  best_found_ff <= 1'b0;
                  pl_found_ff  <= 1'b0;
                  rfree_found_ff <= 1'b0;
                  expired_ff   <= '0;
                  removed_ff   <= '0;
                  stale_ff     <= 1'b0;
                  for (int s = 0; s < MAX_SERVERS; s++) begin
                     cnt_ff[s] <= '0;
                  end
                  if (req_mode == MODE_SWEEP || req_mode == MODE_REVOKE) begin
                     state_ff <= ST_RRD;
                  end else begin
                     state_ff <= ST_SRD;
                  end
               end
            end
            ST_SRD: begin
               state_ff <= (mode_ff == MODE_ASSIGN && phase_ff) ? ST_MUL : ST_SEV;
            end
            ST_SEV: begin
               if (mode_ff == MODE_ASSIGN) begin
                  if (mark_hit) begin
                     srv_orphan_ff[sidx_ff] <= 1'b1;
                  end
               end else if (mode_ff == MODE_SWEEP) begin
                  if (reap_hit) begin
                     srv_valid_ff[sidx_ff] <= 1'b0;
                     removed_ff <= removed_ff + 1'b1;
                     if (srd_rec.link_held) begin
                        stale_ff <= 1'b1;
                     end
                  end
               end else begin
                  if (!hit_found_ff && s_valid &&
                      ((mode_ff == MODE_DRAIN && srd_rec.id == target_ff) ||
                       (mode_ff != MODE_DRAIN && srd_rec.session == session_ff))) begin
                     hit_found_ff <= 1'b1;
                     hit_idx_ff   <= sidx_ff;
                     hit_rec_ff   <= srd_rec;
                  end
                  if (rev_take) begin
                     rev_found_ff <= 1'b1;
                     rev_idx_ff   <= sidx_ff;
                     rev_rec_ff   <= srd_rec;
                  end
                  if (s_valid) begin
                     used_ff <= used_ff + 1'b1;
                  end else if (!free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= sidx_ff;
                  end
               end
               if (s_last) begin
                  sidx_ff <= '0;
                  state_ff <= (mode_ff == MODE_ASSIGN) ? ST_RRD : ST_FIN;
               end else begin
                  sidx_ff <= sidx_ff + 1'b1;
                  state_ff <= ST_SRD;
               end
            end
            ST_MUL: begin
               cur_rec_ff <= srd_rec;
               cur_num_ff <= sel_num;
               cur_ok_ff  <= sel_ok;
               lhs_ff <= PROD_W'(sel_num * best_rec_ff.capacity);
               rhs_ff <= PROD_W'(best_num_ff * srd_rec.capacity);
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (cmp_take) begin
                  best_found_ff <= 1'b1;
                  best_rec_ff   <= cur_rec_ff;
                  best_num_ff   <= cur_num_ff;
               end
               if (s_last) begin
                  state_ff <= ST_FIN;
               end else begin
                  sidx_ff <= sidx_ff + 1'b1;
                  state_ff <= ST_SRD;
               end
            end
            ST_RRD: begin
               state_ff <= ST_REV;
            end
            ST_REV: begin
               if (mode_ff == MODE_SWEEP) begin
                  if (res_valid_ff[ridx_ff] && rrd_rec.expiry <= now_ff) begin
                     res_valid_ff[ridx_ff] <= 1'b0;
                     expired_ff <= expired_ff + 1'b1;
                  end
               end else begin
                  if (!pl_found_ff && res_valid_ff[ridx_ff] && rrd_rec.player == player_ff) begin
                     pl_found_ff  <= 1'b1;
                     pl_idx_ff    <= ridx_ff;
                     pl_ticket_ff <= rrd_rec.ticket;
                  end
                  if (!rfree_found_ff && !res_valid_ff[ridx_ff]) begin
                     rfree_found_ff <= 1'b1;
                     rfree_idx_ff   <= ridx_ff;
                  end
                  if (mode_ff == MODE_ASSIGN && res_live) begin
                     for (int s = 0; s < MAX_SERVERS; s++) begin
                        if (rrd_rec.server == srv_id_ff[s]) begin
                           cnt_ff[s] <= cnt_ff[s] + 1'b1;
                        end
                     end
                  end
               end
               if (r_last) begin
                  ridx_ff <= '0;
                  if (mode_ff == MODE_REVOKE) begin
                     state_ff <= ST_FIN;
                  end else begin
                     phase_ff <= 1'b1;
                     sidx_ff  <= '0;
                     state_ff <= ST_SRD;
                  end
               end else begin
                  ridx_ff <= ridx_ff + 1'b1;
                  state_ff <= ST_RRD;
               end
            end
            ST_FIN: begin
               state_ff       <= ST_IDLE;
               rsp_strobe_ff  <= 1'b1;
               rsp_status_ff  <= STATUS_OK;
               rsp_chosen_ff  <= 16'd0;
               rsp_need_ff    <= 1'b0;
               rsp_stale_ff   <= 1'b0;
               rsp_ticket_ff  <= 32'd0;
               rsp_host_ff    <= 32'd0;
               rsp_port_ff    <= 16'd0;
               rsp_expired_ff <= '0;
               rsp_removed_ff <= '0;
               case (mode_ff)
                  MODE_REGISTER: begin
                     if (hit_found_ff) begin
                        rsp_chosen_ff <= hit_rec_ff.id;
                     end else if (rev_found_ff) begin
                        srv_orphan_ff[rev_idx_ff] <= 1'b0;
                        rsp_chosen_ff <= rev_rec_ff.id;
                        rsp_need_ff   <= 1'b1;
                        rsp_stale_ff  <= rev_rec_ff.link_held;
                     end else if (reg_full) begin
                        rsp_status_ff <= STATUS_FULL;
                     end else begin
                        srv_valid_ff[free_idx_ff]  <= 1'b1;
                        srv_orphan_ff[free_idx_ff] <= 1'b0;
                        srv_id_ff[free_idx_ff]     <= next_server_ff;
                        next_server_ff <= (next_server_ff == 16'hFFFF) ? 16'd1
                                                                       : next_server_ff + 16'd1;
                        rsp_chosen_ff <= next_server_ff;
                        rsp_need_ff   <= 1'b1;
                     end
                     if (hit_found_ff) begin
                        srv_orphan_ff[hit_idx_ff] <= 1'b0;
                     end
                  end
                  MODE_HEARTBEAT: begin
                     if (hit_found_ff) begin
                        srv_orphan_ff[hit_idx_ff] <= 1'b0;
                     end else begin
                        rsp_status_ff <= STATUS_NOT_FOUND;
                     end
                  end
                  MODE_UNREGISTER: begin
                     if (hit_found_ff) begin
                        srv_valid_ff[hit_idx_ff] <= 1'b0;
                        rsp_stale_ff <= hit_rec_ff.link_held;
                     end else begin
                        rsp_status_ff <= STATUS_NOT_FOUND;
                     end
                  end
                  MODE_LINK_DOWN: begin
                     if (hit_found_ff) begin
                        srv_orphan_ff[hit_idx_ff] <= 1'b1;
                        rsp_stale_ff <= hit_rec_ff.link_held;
                     end else begin
                        rsp_status_ff <= STATUS_NOT_FOUND;
                     end
                  end
                  MODE_DRAIN: begin
                     if (!hit_found_ff) begin
                        rsp_status_ff <= STATUS_NOT_FOUND;
                     end
                  end
                  MODE_ASSIGN: begin
                     if (!best_found_ff) begin
                        rsp_status_ff <= STATUS_NO_SERVER;
                     end else if (!pl_found_ff && !rfree_found_ff) begin
                        rsp_status_ff <= STATUS_RES_FULL;
                     end else begin
                        res_valid_ff[rwr_addr] <= 1'b1;
                        next_ticket_ff <= (next_ticket_ff == 32'hFFFF_FFFF) ? 32'd1
                                                                            : next_ticket_ff + 32'd1;
                        rsp_ticket_ff <= next_ticket_ff;
                        rsp_chosen_ff <= best_rec_ff.id;
                        rsp_host_ff   <= best_rec_ff.host;
                        rsp_port_ff   <= best_rec_ff.port;
                     end
                  end
                  MODE_SWEEP: begin
                     rsp_expired_ff <= expired_ff;
                     rsp_removed_ff <= removed_ff;
                     rsp_stale_ff   <= stale_ff;
                  end
                  default: begin
                     if (pl_found_ff && pl_ticket_ff == ticket_in_ff) begin
                        res_valid_ff[pl_idx_ff] <= 1'b0;
                     end else begin
                        rsp_status_ff <= STATUS_NOT_FOUND;
                     end
                  end
               endcase
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_chosen_server = rsp_chosen_ff;
   assign rsp_need_link     = rsp_need_ff;
   assign rsp_stale_link    = rsp_stale_ff;
   assign rsp_ticket_out    = rsp_ticket_ff;
   assign rsp_chosen_host   = rsp_host_ff;
   assign rsp_chosen_port   = rsp_port_ff;
   assign rsp_expired_count = rsp_expired_ff;
   assign rsp_removed_count = rsp_removed_ff;

   `LLSR_ASSERT_NEXT(a_fin_strobes, clock, reset, state_ff == ST_FIN, rsp_strobe_ff)
   `LLSR_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   `LLSR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `LLSR_ASSERT_SAME(a_ids_nonzero, clock, reset, 1'b1,
      next_server_ff != 16'd0 && next_ticket_ff != 32'd0)

endmodule

// File: src/llsr_ram.sv
// ----------------------------------------------------------------------------
// Registry RAM
// Simple dual port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module llsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/least_loaded_server_registry_unit_tb.sv
// ----------------------------------------------------------------------------
// Least loaded server registry testbench
// Drives register, heartbeat, unregister, link down, drain, assign, sweep and
// revoke words through the command port and keeps its own copy of both tables
// to predict every reply. Replies are checked field by field in order. The run
// covers several register settings, a short directed part and random traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import llsr_pkg::*;

   typedef struct {
      logic [2:0]  mode;
      logic [63:0] session;
      logic [31:0] host;
      logic [15:0] port;
      logic [15:0] cap;
      logic [15:0] cur;
      logic [47:0] now;
      logic [63:0] player;
      logic [31:0] hold;
      logic [15:0] target;
      logic        drain;
      logic [31:0] ticket;
   } op_t;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] chosen;
      logic        need;
      logic        stale;
      logic [31:0] ticket;
      logic [31:0] host;
      logic [15:0] port;
      logic [6:0]  expired;
      logic [4:0]  removed;
   } reply_t;

   localparam int NSRV = 16;
   localparam int NRES = 64;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_mode = '0;
   logic [63:0] req_session_key = '0;
   logic [31:0] req_host_key = '0;
   logic [15:0] req_host_port = '0;
   logic [15:0] req_seat_capacity = '0;
   logic [15:0] req_seat_current = '0;
   logic [47:0] req_now_time = '0;
   logic [63:0] req_player_key = '0;
   logic [31:0] req_hold_time = '0;
   logic [15:0] req_target_server = '0;
   logic        req_drain_flag = 1'b0;
   logic [31:0] req_ticket_in = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_chosen_server;
   logic        rsp_need_link;
   logic        rsp_stale_link;
   logic [31:0] rsp_ticket_out;
   logic [31:0] rsp_chosen_host;
   logic [15:0] rsp_chosen_port;
   logic [6:0]  rsp_expired_count;
   logic [4:0]  rsp_removed_count;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   least_loaded_server_registry_unit u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Registry copy used for prediction.
   logic [4:0]  cfg_limit;
   logic [15:0] cfg_period;
   logic [7:0]  cfg_missed;
   logic [31:0] cfg_grace;
   logic        s_valid [NSRV];
   logic        s_orphan [NSRV];
   logic        s_drain [NSRV];
   logic        s_link [NSRV];
   logic [15:0] s_id [NSRV];
   logic [63:0] s_session [NSRV];
   logic [31:0] s_host [NSRV];
   logic [15:0] s_port [NSRV];
   logic [15:0] s_cap [NSRV];
   logic [15:0] s_load [NSRV];
   logic [47:0] s_beat [NSRV];
   logic [47:0] s_otime [NSRV];
   logic        r_valid [NRES];
   logic [63:0] r_player [NRES];
   logic [15:0] r_server [NRES];
   logic [47:0] r_expiry [NRES];
   logic [31:0] r_ticket [NRES];
   logic [15:0] next_server_id;
   logic [31:0] next_ticket;

   op_t    pending_ops[$];
   reply_t awaited_replies[$];
   op_t    cur_op;
   int     gap_left = 0;
   bit     calm = 0;
   int     errors = 0;
   int     words_in = 0;
   int     words_out = 0;
   int     mode_hits [8];
   int     status_hits [8];
   logic [47:0] now_ms = 48'd1000;

   function automatic int find_session(logic [63:0] key);
      for (int i = 0; i < NSRV; i++)
         if (s_valid[i] && s_session[i] == key) return i;
      return -1;
   endfunction

   function automatic int find_player(logic [63:0] key);
      for (int i = 0; i < NRES; i++)
         if (r_valid[i] && r_player[i] == key) return i;
      return -1;
   endfunction

   function automatic void load_entry(int k, op_t o);
      s_session[k] = o.session;
      s_host[k] = o.host;
      s_port[k] = o.port;
      s_cap[k] = o.cap;
      s_load[k] = o.cur;
      s_beat[k] = o.now;
      s_orphan[k] = 1'b0;
      s_otime[k] = '0;
   endfunction

   function automatic reply_t registry_step(op_t o);
      reply_t r;
      int k, best, used, lim;
      longint unsigned timeout, num, best_num, lhs, rhs, expv;
      r = '{default: '0};
      case (o.mode)
         MODE_REGISTER: begin
            k = find_session(o.session);
            if (k >= 0) begin
               load_entry(k, o);
               r.chosen = s_id[k];
            end else begin
               for (int i = 0; i < NSRV; i++) begin
                  if (!s_valid[i] || !s_orphan[i] || s_host[i] != o.host || s_port[i] != o.port)
                     continue;
                  if (k < 0 || s_otime[i] > s_otime[k] ||
                      (s_otime[i] == s_otime[k] && s_id[i] < s_id[k]))
                     k = i;
               end
               if (k >= 0) begin
                  r.stale = s_link[k];
                  s_link[k] = 1'b1;
                  load_entry(k, o);
                  r.chosen = s_id[k];
                  r.need = 1'b1;
               end else begin
                  used = 0;
                  lim = (cfg_limit > NSRV) ? NSRV : cfg_limit;
                  for (int i = 0; i < NSRV; i++) begin
                     if (s_valid[i]) used++;
                     else if (k < 0) k = i;
                  end
                  if (used >= lim || k < 0) begin
                     r.status = STATUS_FULL;
                  end else begin
                     s_valid[k] = 1'b1;
                     s_id[k] = next_server_id;
                     next_server_id++;
                     if (next_server_id == 0) next_server_id = 1;
                     load_entry(k, o);
                     s_drain[k] = 1'b0;
                     s_link[k] = 1'b1;
                     r.chosen = s_id[k];
                     r.need = 1'b1;
                  end
               end
            end
         end
         MODE_HEARTBEAT: begin
            k = find_session(o.session);
            if (k < 0) r.status = STATUS_NOT_FOUND;
            else begin
               s_load[k] = o.cur;
               s_beat[k] = o.now;
               s_orphan[k] = 1'b0;
               s_otime[k] = '0;
            end
         end
         MODE_UNREGISTER: begin
            k = find_session(o.session);
            if (k < 0) r.status = STATUS_NOT_FOUND;
            else begin
               r.stale = s_link[k];
               s_link[k] = 1'b0;
               s_valid[k] = 1'b0;
            end
         end
         MODE_LINK_DOWN: begin
            k = find_session(o.session);
            if (k < 0) r.status = STATUS_NOT_FOUND;
            else begin
               if (!s_orphan[k]) begin
                  s_orphan[k] = 1'b1;
                  s_otime[k] = o.now;
               end
               r.stale = s_link[k];
               s_link[k] = 1'b0;
            end
         end
         MODE_DRAIN: begin
            r.status = STATUS_NOT_FOUND;
            for (int i = 0; i < NSRV; i++) begin
               if (s_valid[i] && s_id[i] == o.target) begin
                  s_drain[i] = o.drain;
                  r.status = STATUS_OK;
                  break;
               end
            end
         end
         MODE_ASSIGN: begin
            timeout = longint'(cfg_period) * cfg_missed;
            best = -1;
            best_num = 0;
            for (int i = 0; i < NSRV; i++) begin
               if (s_valid[i] && !s_orphan[i] && longint'(s_beat[i]) + timeout < o.now) begin
                  s_orphan[i] = 1'b1;
                  s_otime[i] = o.now;
               end
            end
            for (int i = 0; i < NSRV; i++) begin
               if (!s_valid[i] || s_orphan[i] || s_cap[i] == 0 || s_drain[i]) continue;
               num = s_load[i];
               for (int j = 0; j < NRES; j++)
                  if (r_valid[j] && r_server[j] == s_id[i] && r_expiry[j] > o.now) num++;
               if (best < 0) begin
                  best = i;
                  best_num = num;
                  continue;
               end
               lhs = num * s_cap[best];
               rhs = best_num * s_cap[i];
               if (lhs < rhs || (lhs == rhs && s_id[i] < s_id[best])) begin
                  best = i;
                  best_num = num;
               end
            end
            if (best < 0) begin
               r.status = STATUS_NO_SERVER;
            end else begin
               k = find_player(o.player);
               if (k < 0)
                  for (int i = 0; i < NRES; i++)
                     if (!r_valid[i]) begin
                        k = i;
                        break;
                     end
               if (k < 0) begin
                  r.status = STATUS_RES_FULL;
               end else begin
                  expv = longint'(o.now) + o.hold;
                  if (expv > TIME_MAX) expv = TIME_MAX;
                  r_valid[k] = 1'b1;
                  r_player[k] = o.player;
                  r_server[k] = s_id[best];
                  r_expiry[k] = expv[47:0];
                  r_ticket[k] = next_ticket;
                  r.ticket = next_ticket;
                  next_ticket++;
                  if (next_ticket == 0) next_ticket = 1;
                  r.chosen = s_id[best];
                  r.host = s_host[best];
                  r.port = s_port[best];
               end
            end
         end
         MODE_SWEEP: begin
            for (int i = 0; i < NRES; i++) begin
               if (r_valid[i] && r_expiry[i] <= o.now) begin
                  r_valid[i] = 1'b0;
                  r.expired++;
               end
            end
            for (int i = 0; i < NSRV; i++) begin
               if (s_valid[i] && s_orphan[i] && longint'(s_otime[i]) + cfg_grace < o.now) begin
                  if (s_link[i]) r.stale = 1'b1;
                  s_link[i] = 1'b0;
                  s_valid[i] = 1'b0;
                  r.removed++;
               end
            end
         end
         default: begin
            k = find_player(o.player);
            if (k < 0 || r_ticket[k] != o.ticket) r.status = STATUS_NOT_FOUND;
            else r_valid[k] = 1'b0;
         end
      endcase
      return r;
   endfunction

   // Driver: a word is taken at an edge where start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_replies.push_back(registry_step(cur_op));
            mode_hits[cur_op.mode]++;
            words_in++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_ops.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 3);
               start <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               cur_op = pending_ops.pop_front();
               req_mode <= cur_op.mode;
               req_session_key <= cur_op.session;
               req_host_key <= cur_op.host;
               req_host_port <= cur_op.port;
               req_seat_capacity <= cur_op.cap;
               req_seat_current <= cur_op.cur;
               req_now_time <= cur_op.now;
               req_player_key <= cur_op.player;
               req_hold_time <= cur_op.hold;
               req_target_server <= cur_op.target;
               req_drain_flag <= cur_op.drain;
               req_ticket_in <= cur_op.ticket;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // Monitor: every reply word is compared with the oldest prediction.
   always @(posedge clock) begin
      reply_t w;
      if (!reset && rsp_strobe) begin
         if (awaited_replies.size() == 0) begin
            $error("reply word with no prediction waiting");
            errors++;
         end else begin
            w = awaited_replies.pop_front();
            words_out++;
            status_hits[w.status]++;
            check_field("status", w.status, rsp_status);
            check_field("chosen_server", w.chosen, rsp_chosen_server);
            check_field("need_link", w.need, rsp_need_link);
            check_field("stale_link", w.stale, rsp_stale_link);
            check_field("ticket_out", w.ticket, rsp_ticket_out);
            check_field("chosen_host", w.host, rsp_chosen_host);
            check_field("chosen_port", w.port, rsp_chosen_port);
            check_field("expired_count", w.expired, rsp_expired_count);
            check_field("removed_count", w.removed, rsp_removed_count);
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_TABLE_LIMIT: cfg_limit = value[4:0];
         CSR_HB_PERIOD: cfg_period = value[15:0];
         CSR_MISSED_BEATS: cfg_missed = value[7:0];
         default: cfg_grace = value;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(int lim, int period, int missed, logic [31:0] grace);
      write_reg(CSR_TABLE_LIMIT, lim);
      write_reg(CSR_HB_PERIOD, period);
      write_reg(CSR_MISSED_BEATS, missed);
      write_reg(CSR_ORPHAN_GRACE, grace);
   endtask

   task automatic settle();
      while (pending_ops.size() != 0 || start || awaited_replies.size() != 0 || busy)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send(op_t o);
      while (pending_ops.size() != 0) @(posedge clock);
      pending_ops.push_back(o);
   endtask

   function automatic op_t blank_op(logic [2:0] mode);
      op_t o;
      o = '{default: '0};
      o.mode = mode;
      o.now = now_ms;
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly well-formed traffic over small pools of sessions, hosts and
   // players so that refresh, revival, ties and revoke matches happen often.
   function automatic op_t random_op(bit flood);
      op_t o;
      int pick, k;
      pick = $urandom_range(0, 99);
      now_ms = now_ms + $urandom_range(0, 700);
      if (!flood && $urandom_range(0, 99) < 8) begin
         o.mode = $urandom();
         o.session = rand64();
         o.host = $urandom();
         o.port = $urandom();
         o.cap = $urandom();
         o.cur = $urandom();
         o.now = {$urandom(), $urandom()};
         o.player = rand64();
         o.hold = $urandom();
         o.target = $urandom();
         o.drain = $urandom();
         o.ticket = $urandom();
         return o;
      end
      if (flood) pick = 40;
      o = blank_op(MODE_ASSIGN);
      if (pick < 20) o.mode = MODE_REGISTER;
      else if (pick < 34) o.mode = MODE_HEARTBEAT;
      else if (pick < 38) o.mode = MODE_UNREGISTER;
      else if (pick < 44 && !flood) o.mode = MODE_LINK_DOWN;
      else if (pick < 50 && !flood) o.mode = MODE_DRAIN;
      else if (pick < 80 || flood) o.mode = MODE_ASSIGN;
      else if (pick < 88) o.mode = MODE_SWEEP;
      else o.mode = MODE_REVOKE;
      o.session = 64'hC0DE_0000_0000_0000 + $urandom_range(0, 23);
      o.host = 32'h0A00_0000 + $urandom_range(0, 5);
      o.port = 16'd7000 + $urandom_range(0, 2);
      o.cap = ($urandom_range(0, 9) == 0) ? 16'd0 : $urandom_range(1, 40);
      o.cur = $urandom_range(0, 50);
      o.player = flood ? 64'h5000 + $urandom_range(0, 99) : 64'h5000 + $urandom_range(0, 79);
      o.hold = flood ? 32'hFFFF_FFFF : $urandom_range(0, 20000);
      o.target = $urandom_range(0, next_server_id + 1);
      k = $urandom_range(0, NSRV - 1);
      if (s_valid[k] && $urandom_range(0, 3) != 0) o.target = s_id[k];
      o.drain = $urandom();
      o.ticket = $urandom_range(0, next_ticket);
      if (o.mode == MODE_REVOKE && $urandom_range(0, 9) < 7) begin
         k = $urandom_range(0, NRES - 1);
         for (int i = 0; i < NRES; i++)
            if (r_valid[(k + i) % NRES]) begin
               o.player = r_player[(k + i) % NRES];
               o.ticket = r_ticket[(k + i) % NRES];
               break;
            end
      end
      return o;
   endfunction

   task automatic run_random(int count, bit flood);
      for (int n = 0; n < count; n++) begin
         while (pending_ops.size() != 0) @(posedge clock);
         pending_ops.push_back(random_op(flood));
      end
   endtask

   initial begin
      op_t o;
      cfg_limit = 5'd16;
      cfg_period = 16'd1000;
      cfg_missed = 8'd3;
      cfg_grace = 32'd10000;
      next_server_id = 16'd1;
      next_ticket = 32'd1;
      for (int i = 0; i < NSRV; i++) begin
         s_valid[i] = 1'b0;
         s_orphan[i] = 1'b0;
      end
      for (int i = 0; i < NRES; i++) r_valid[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: lookups that miss, empty tables, refresh, drain,
      // revival of an orphan, saturated expiry and extreme field values.
      for (int m = MODE_HEARTBEAT; m <= MODE_REVOKE; m++) send(blank_op(m));
      o = blank_op(MODE_REGISTER);
      o.session = 64'hFFFF_FFFF_FFFF_FFFF;
      o.host = 32'hFFFF_FFFF;
      o.port = 16'hFFFF;
      o.cap = 16'hFFFF;
      o.cur = 16'hFFFF;
      send(o);
      o.cur = 16'd0;
      send(o);
      o = blank_op(MODE_REGISTER);
      o.session = 64'd5;
      o.cap = 16'd0;
      send(o);
      o = blank_op(MODE_DRAIN);
      o.target = 16'd1;
      o.drain = 1'b1;
      send(o);
      send(blank_op(MODE_ASSIGN));
      o.drain = 1'b0;
      send(o);
      o = blank_op(MODE_ASSIGN);
      o.player = 64'hFFFF_FFFF_FFFF_FFFF;
      o.hold = 32'hFFFF_FFFF;
      o.now = TIME_MAX;
      send(o);
      o = blank_op(MODE_LINK_DOWN);
      o.session = 64'hFFFF_FFFF_FFFF_FFFF;
      send(o);
      o = blank_op(MODE_REGISTER);
      o.session = 64'd9;
      o.host = 32'hFFFF_FFFF;
      o.port = 16'hFFFF;
      o.cap = 16'd3;
      send(o);
      o = blank_op(MODE_REVOKE);
      o.player = 64'hFFFF_FFFF_FFFF_FFFF;
      o.ticket = 32'd1;
      send(o);
      o = blank_op(MODE_UNREGISTER);
      o.session = 64'd9;
      send(o);
      o = blank_op(MODE_SWEEP);
      o.now = TIME_MAX;
      send(o);
      settle();

      configure(0, 0, 0, 0);
      o = blank_op(MODE_REGISTER);
      send(o);
      run_random(100, 0);
      settle();

      configure(16, 65535, 255, 32'hFFFF_FFFF);
      run_random(80, 1);
      run_random(100, 0);
      settle();

      configure(3, 500, 2, 2000);
      run_random(150, 0);
      settle();

      configure(16, 1000, 3, 10000);
      run_random(150, 0);
      calm = 1;
      run_random(100, 0);
      settle();
      repeat (250) @(posedge clock);

      $display("Sent %0d words and checked %0d replies over five register settings.",
               words_in, words_out);
      $display("Replies by status: ok %0d, full %0d, not found %0d, no server %0d, res full %0d.",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
      if (errors == 0 && awaited_replies.size() == 0) begin
         $display("** least_loaded_server_registry_unit: PASSED **");
      end else begin
         $display("** least_loaded_server_registry_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("** least_loaded_server_registry_unit: FAILED **");
      $finish;
   end

endmodule
